FILE: hdl/vaal_pkg.sv
// shared types and constants for the vector angle and length block
`timescale 1ns / 1ps

package vaal_pkg;

  // angle accumulator: degrees with 24 fraction bits
  localparam int ZFRAC = 24;
  localparam int ZW = 32;
  localparam int TABLE_LEN = 32;
  localparam int ANGLE_INT_BITS = 9;

  // atan(2^-i) in degrees, 24 fraction bits, rounded to nearest
  localparam logic signed [ZW-1:0] ATAN_TAB [TABLE_LEN] = '{
    32'sd754974720, 32'sd445687602, 32'sd235489088, 32'sd119537938,
    32'sd60000934, 32'sd30029717, 32'sd15018523, 32'sd7509720,
    32'sd3754917, 32'sd1877466, 32'sd938734, 32'sd469367,
    32'sd234684, 32'sd117342, 32'sd58671, 32'sd29335,
    32'sd14668, 32'sd7334, 32'sd3667, 32'sd1833,
    32'sd917, 32'sd458, 32'sd229, 32'sd115,
    32'sd57, 32'sd29, 32'sd14, 32'sd7,
    32'sd4, 32'sd2, 32'sd1, 32'sd0
  };

  // sign and zero flags of the difference vector
  typedef struct packed {
    logic dx_neg;
    logic dx_zero;
    logic dy_neg;
    logic dy_zero;
  } quad_t;

endpackage

FILE: hdl/vaal_prep.sv
// front end: difference vector, absolute values, squares and their sum
`timescale 1ns / 1ps

module vaal_prep #(
  parameter int COORD_BITS = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  logic signed [COORD_BITS-1:0]  up_start_x,
  input  logic signed [COORD_BITS-1:0]  up_start_y,
  input  logic signed [COORD_BITS-1:0]  up_end_x,
  input  logic signed [COORD_BITS-1:0]  up_end_y,
  output logic                          dn_valid,
  input  logic                          dn_ready,
  output logic [COORD_BITS:0]           dn_a,
  output logic [COORD_BITS:0]           dn_b,
  output logic [2*COORD_BITS+1:0]       dn_sum,
  output vaal_pkg::quad_t               dn_flags
);

  localparam int MAG_BITS = COORD_BITS + 1;
  localparam int NW = 2 * MAG_BITS;

  logic                       v1_r, v2_r, v3_r;
  logic                       rdy1, rdy2, rdy3;
  logic signed [MAG_BITS-1:0] dx, dy;
  logic [MAG_BITS-1:0]        a_nxt, b_nxt;
  vaal_pkg::quad_t            f_nxt;
  logic [MAG_BITS-1:0]        a1_r, b1_r, a2_r, b2_r, a3_r, b3_r;
  vaal_pkg::quad_t            f1_r, f2_r, f3_r;
  logic [NW-1:0]              sa2_r, sb2_r, sum3_r;

  assign rdy3 = !v3_r || dn_ready;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign up_ready = rdy1;

  always_comb begin
    dx = MAG_BITS'(up_start_x) - MAG_BITS'(up_end_x);
    dy = MAG_BITS'(up_start_y) - MAG_BITS'(up_end_y);
    a_nxt = dx[MAG_BITS-1] ? MAG_BITS'(-dx) : MAG_BITS'(dx);
    b_nxt = dy[MAG_BITS-1] ? MAG_BITS'(-dy) : MAG_BITS'(dy);
    f_nxt.dx_neg = dx[MAG_BITS-1];
    f_nxt.dx_zero = (dx == '0);
    f_nxt.dy_neg = dy[MAG_BITS-1];
    f_nxt.dy_zero = (dy == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= up_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && up_valid) begin
      a1_r <= a_nxt;
      b1_r <= b_nxt;
      f1_r <= f_nxt;
    end
    if (rdy2 && v1_r) begin
      sa2_r <= NW'(a1_r) * NW'(a1_r);
      sb2_r <= NW'(b1_r) * NW'(b1_r);
      a2_r <= a1_r;
      b2_r <= b1_r;
      f2_r <= f1_r;
    end
    if (rdy3 && v2_r) begin
      sum3_r <= sa2_r + sb2_r;
      a3_r <= a2_r;
      b3_r <= b2_r;
      f3_r <= f2_r;
    end
  end

  assign dn_valid = v3_r;
  assign dn_a = a3_r;
  assign dn_b = b3_r;
  assign dn_sum = sum3_r;
  assign dn_flags = f3_r;

endmodule

FILE: hdl/vaal_cell.sv
// one cell of the chain: a cordic vectoring step and a square root digit step, each passed through past its range
`timescale 1ns / 1ps

module vaal_cell #(
  parameter int COORD_BITS = 20,
  parameter int CORDIC_STAGES = 18,
  parameter int STAGE = 0
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              up_valid,
  output logic                              up_ready,
  input  logic signed [COORD_BITS+2:0]      up_x,
  input  logic signed [COORD_BITS+2:0]      up_y,
  input  logic signed [vaal_pkg::ZW-1:0]    up_z,
  input  logic [COORD_BITS+3:0]             up_rem,
  input  logic [COORD_BITS:0]               up_root,
  input  logic [2*COORD_BITS+1:0]           up_rad,
  input  vaal_pkg::quad_t                   up_flags,
  output logic                              dn_valid,
  input  logic                              dn_ready,
  output logic signed [COORD_BITS+2:0]      dn_x,
  output logic signed [COORD_BITS+2:0]      dn_y,
  output logic signed [vaal_pkg::ZW-1:0]    dn_z,
  output logic [COORD_BITS+3:0]             dn_rem,
  output logic [COORD_BITS:0]               dn_root,
  output logic [2*COORD_BITS+1:0]           dn_rad,
  output vaal_pkg::quad_t                   dn_flags
);

  localparam int MAG_BITS = COORD_BITS + 1;
  localparam int XW = COORD_BITS + 3;
  localparam int RW = MAG_BITS + 3;
  localparam int NW = 2 * MAG_BITS;

  logic                          v_r, rdy;
  logic signed [XW-1:0]          x_nxt, y_nxt, x_r, y_r;
  logic signed [vaal_pkg::ZW-1:0] z_nxt, z_r;
  logic [RW-1:0]                 rem_nxt, rem_r;
  logic [MAG_BITS-1:0]           root_nxt, root_r;
  logic [NW-1:0]                 rad_nxt, rad_r;
  vaal_pkg::quad_t               flags_r;

  generate
    if (STAGE < CORDIC_STAGES && STAGE < vaal_pkg::TABLE_LEN) begin : g_rot
      localparam logic signed [vaal_pkg::ZW-1:0] ANG = vaal_pkg::ATAN_TAB[STAGE];
      logic signed [XW-1:0] xs, ys;
      always_comb begin
        xs = up_x >>> STAGE;
        ys = up_y >>> STAGE;
        // drive y toward zero, summing the rotation angle
        if (up_y > 0) begin
          x_nxt = up_x + ys;
          y_nxt = up_y - xs;
          z_nxt = up_z + ANG;
        end else begin
          x_nxt = up_x - ys;
          y_nxt = up_y + xs;
          z_nxt = up_z - ANG;
        end
      end
    end else begin : g_rot_pass
      assign x_nxt = up_x;
      assign y_nxt = up_y;
      assign z_nxt = up_z;
    end

    if (STAGE < MAG_BITS) begin : g_sqrt
      logic [RW-1:0] rem_sh, trial;
      always_comb begin
        rem_sh = {up_rem[RW-3:0], up_rad[NW-1 -: 2]};
        trial = RW'({up_root, 2'b01});
        rad_nxt = {up_rad[NW-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_nxt = rem_sh - trial;
          root_nxt = {up_root[MAG_BITS-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          root_nxt = {up_root[MAG_BITS-2:0], 1'b0};
        end
      end
    end else begin : g_sqrt_pass
      assign rem_nxt = up_rem;
      assign root_nxt = up_root;
      assign rad_nxt = up_rad;
    end
  endgenerate

  assign rdy = !v_r || dn_ready;
  assign up_ready = rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (rdy) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy && up_valid) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
      rem_r <= rem_nxt;
      root_r <= root_nxt;
      rad_r <= rad_nxt;
      flags_r <= up_flags;
    end
  end

  assign dn_valid = v_r;
  assign dn_x = x_r;
  assign dn_y = y_r;
  assign dn_z = z_r;
  assign dn_rem = rem_r;
  assign dn_root = root_r;
  assign dn_rad = rad_r;
  assign dn_flags = flags_r;

endmodule

FILE: hdl/vaal_finish.sv
// back end: angle rounding, quadrant mapping and the output register
`timescale 1ns / 1ps

module vaal_finish #(
  parameter int COORD_BITS = 20,
  parameter int ANGLE_FRAC_BITS = 8
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            up_valid,
  output logic                                            up_ready,
  input  logic signed [vaal_pkg::ZW-1:0]                  up_z,
  input  logic [COORD_BITS:0]                             up_root,
  input  vaal_pkg::quad_t                                 up_flags,
  output logic                                            dn_valid,
  input  logic                                            dn_ready,
  output logic [vaal_pkg::ANGLE_INT_BITS+ANGLE_FRAC_BITS-1:0] dn_angle,
  output logic [COORD_BITS:0]                             dn_mag
);

  localparam int MAG_BITS = COORD_BITS + 1;
  localparam int AW = vaal_pkg::ANGLE_INT_BITS + ANGLE_FRAC_BITS;
  localparam int SH = vaal_pkg::ZFRAC - ANGLE_FRAC_BITS;
  localparam logic [vaal_pkg::ZW-1:0] ZTOP = vaal_pkg::ZW'(90) << vaal_pkg::ZFRAC;
  localparam logic [vaal_pkg::ZW-1:0] ZHALF = vaal_pkg::ZW'(1) << (SH - 1);
  localparam logic [AW:0] DEG90 = (AW+1)'(90) << ANGLE_FRAC_BITS;
  localparam logic [AW:0] DEG180 = (AW+1)'(180) << ANGLE_FRAC_BITS;
  localparam logic [AW:0] DEG360 = (AW+1)'(360) << ANGLE_FRAC_BITS;

  logic                         v_r, rdy;
  logic [vaal_pkg::ZW-1:0]      zc, zq;
  logic [AW:0]                  q, t, ang, ang_w;
  logic                         dx_pos;
  logic [AW-1:0]                angle_nxt, angle_r;
  logic [MAG_BITS-1:0]          mag_r;

  always_comb begin
    // clamp to the first quadrant, round to the output grid, clamp again
    if (up_z < 0) begin
      zc = '0;
    end else if (vaal_pkg::ZW'(up_z) > ZTOP) begin
      zc = ZTOP;
    end else begin
      zc = vaal_pkg::ZW'(up_z);
    end
    zq = (zc + ZHALF) >> SH;
    q = (zq > vaal_pkg::ZW'(DEG90)) ? DEG90 : zq[AW:0];

    // axis vectors take the exact angle
    if (up_flags.dy_zero) begin
      t = '0;
    end else if (up_flags.dx_zero) begin
      t = DEG90;
    end else begin
      t = q;
    end

    dx_pos = !up_flags.dx_neg && !up_flags.dx_zero;
    if (dx_pos && !up_flags.dy_neg) begin
      ang = t;
    end else if (!dx_pos && !up_flags.dy_neg && !up_flags.dy_zero) begin
      ang = DEG180 - t;
    end else if (up_flags.dx_neg && (up_flags.dy_neg || up_flags.dy_zero)) begin
      ang = DEG180 + t;
    end else begin
      ang = DEG360 - t;
    end
    ang_w = (ang >= DEG360) ? ang - DEG360 : ang;

    if (up_flags.dx_zero && up_flags.dy_zero) begin
      angle_nxt = '0;
    end else begin
      angle_nxt = ang_w[AW-1:0];
    end
  end

  assign rdy = !v_r || dn_ready;
  assign up_ready = rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (rdy) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy && up_valid) begin
      angle_r <= angle_nxt;
      mag_r <= up_root;
    end
  end

  assign dn_valid = v_r;
  assign dn_angle = angle_r;
  assign dn_mag = mag_r;

endmodule

FILE: hdl/vector_angle_and_length.sv
// top level: direction and length of the vector between two points
// throughput: one transaction per cycle while the output is not stalled, each cell of the chain holds one item
// the cell chain (at most one cordic step and one root digit per cell) sets the latency
// a stalled output backs up stage by stage, so empty stages still take input
// reset clears the valid flags of every stage; data registers are not reset
`timescale 1ns / 1ps

module vector_angle_and_length #(
  parameter int COORD_BITS = 20,
  parameter int ANGLE_FRAC_BITS = 8,
  parameter int CORDIC_STAGES = 18
) (
  input  logic                                                clk,
  input  logic                                                rst_n,
  input  logic                                                in_valid,
  output logic                                                in_ready,
  input  logic signed [COORD_BITS-1:0]                        in_start_x,
  input  logic signed [COORD_BITS-1:0]                        in_start_y,
  input  logic signed [COORD_BITS-1:0]                        in_end_x,
  input  logic signed [COORD_BITS-1:0]                        in_end_y,
  output logic                                                out_valid,
  input  logic                                                out_ready,
  output logic [vaal_pkg::ANGLE_INT_BITS+ANGLE_FRAC_BITS-1:0] out_angle_deg,
  output logic [COORD_BITS:0]                                 out_magnitude
);

  localparam int MAG_BITS = COORD_BITS + 1;
  localparam int XW = COORD_BITS + 3;
  localparam int RW = MAG_BITS + 3;
  localparam int NW = 2 * MAG_BITS;
  localparam int NCELL = (CORDIC_STAGES > MAG_BITS) ? CORDIC_STAGES : MAG_BITS;

  logic [MAG_BITS-1:0]           pre_a, pre_b;
  logic [NW-1:0]                 pre_sum;
  vaal_pkg::quad_t               pre_flags;

  logic                          cell_v   [NCELL+1];
  logic                          cell_rdy [NCELL+1];
  logic signed [XW-1:0]          cell_x   [NCELL+1];
  logic signed [XW-1:0]          cell_y   [NCELL+1];
  logic signed [vaal_pkg::ZW-1:0] cell_z  [NCELL+1];
  logic [RW-1:0]                 cell_rem [NCELL+1];
  logic [MAG_BITS-1:0]           cell_root[NCELL+1];
  logic [NW-1:0]                 cell_rad [NCELL+1];
  vaal_pkg::quad_t               cell_f   [NCELL+1];

  vaal_prep #(
    .COORD_BITS(COORD_BITS)
  ) u_prep (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (in_valid),
    .up_ready   (in_ready),
    .up_start_x (in_start_x),
    .up_start_y (in_start_y),
    .up_end_x   (in_end_x),
    .up_end_y   (in_end_y),
    .dn_valid   (cell_v[0]),
    .dn_ready   (cell_rdy[0]),
    .dn_a       (pre_a),
    .dn_b       (pre_b),
    .dn_sum     (pre_sum),
    .dn_flags   (pre_flags)
  );

  assign cell_x[0] = signed'({2'b00, pre_a});
  assign cell_y[0] = signed'({2'b00, pre_b});
  assign cell_z[0] = '0;
  assign cell_rem[0] = '0;
  assign cell_root[0] = '0;
  assign cell_rad[0] = pre_sum;
  assign cell_f[0] = pre_flags;

  genvar gi;
  generate
    for (gi = 0; gi < NCELL; gi++) begin : g_cell
      vaal_cell #(
        .COORD_BITS    (COORD_BITS),
        .CORDIC_STAGES (CORDIC_STAGES),
        .STAGE         (gi)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (cell_v[gi]),
        .up_ready (cell_rdy[gi]),
        .up_x     (cell_x[gi]),
        .up_y     (cell_y[gi]),
        .up_z     (cell_z[gi]),
        .up_rem   (cell_rem[gi]),
        .up_root  (cell_root[gi]),
        .up_rad   (cell_rad[gi]),
        .up_flags (cell_f[gi]),
        .dn_valid (cell_v[gi+1]),
        .dn_ready (cell_rdy[gi+1]),
        .dn_x     (cell_x[gi+1]),
        .dn_y     (cell_y[gi+1]),
        .dn_z     (cell_z[gi+1]),
        .dn_rem   (cell_rem[gi+1]),
        .dn_root  (cell_root[gi+1]),
        .dn_rad   (cell_rad[gi+1]),
        .dn_flags (cell_f[gi+1])
      );
    end
  endgenerate

  vaal_finish #(
    .COORD_BITS      (COORD_BITS),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_finish (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (cell_v[NCELL]),
    .up_ready (cell_rdy[NCELL]),
    .up_z     (cell_z[NCELL]),
    .up_root  (cell_root[NCELL]),
    .up_flags (cell_f[NCELL]),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_angle (out_angle_deg),
    .dn_mag   (out_magnitude)
  );

  // input can only be refused when every stage is full behind a stalled output
  a_full_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input refused while the pipeline has room");

  // only the zero vector has length zero, and it reports angle zero
  a_zero_vector: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_magnitude == '0) |-> (out_angle_deg == '0))
    else $error("zero length result with nonzero angle");

  // a result appears only after the last cell held a transaction
  a_out_from_chain: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cell_v[NCELL]))
    else $error("result appeared without a transaction from the cell chain");

endmodule
